// ===== sv/vna_pkg.sv =====
// Shared types and constants for the vertex normal accumulator.
// Holds the function codes, datapath command and status structs.
// No dependencies.
package vna_pkg;

  localparam int VERTEX_COUNT_DEF = 1024;
  localparam int ACC_WIDTH_DEF    = 24;

  localparam int IDX_W     = 10;  // vertex index field
  localparam int IDX_EXT_W = 17;  // wide enough to hold any vertex count
  localparam int POS_W     = 16;  // one Q8.8 position axis
  localparam int VTX_W     = 3 * POS_W;
  localparam int NRM_W     = 16;  // one Q1.14 normal axis
  localparam int VEC_W     = 36;  // signed vector fed to the normaliser
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_TRI   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_WRITE,
    OP_CLEAR,
    OP_POS_RD,
    OP_CROSS,
    OP_ACC_RD,
    OP_ACC_WR,
    OP_LOAD_ACC,
    OP_NRM_LOAD,
    OP_NRM_SHIFT,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_ZERO,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] k;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  a_ok;
    logic  tri_ok;
    logic  m_zero;
    logic  m_big;
    logic  m_small;
    logic  out_full;
    logic  clr_last;
  } dp_status_t;

endpackage

// ===== sv/vna_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/vna_datapath.sv =====
// Datapath: position and accumulator RAMs, cross product, normaliser
// (shift, squares, square root, divider), saturating add, output register.
// Depends on vna_pkg and vna_ram.
module vna_datapath import vna_pkg::*; #(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
  parameter int ACC_WIDTH    = ACC_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic [1:0]            s_tuser_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  output logic                  m_tuser_o
);

  localparam int AW = $clog2(VERTEX_COUNT);
  localparam int AC_W = 3 * ACC_WIDTH;

  function automatic logic [AW-1:0] to_addr(logic [IDX_W-1:0] idx);
    logic [IDX_EXT_W-1:0] ext;
    ext = IDX_EXT_W'(idx);
    return ext[AW-1:0];
  endfunction

  func_e            func_q;
  logic [IDX_W-1:0] idx_q [3];
  logic [VTX_W-1:0] posw_q;
  logic [VTX_W-1:0] p_q [3];
  logic [2:0]       ok;

  logic [VTX_W-1:0] pos_rdata;
  logic [AC_W-1:0]  acc_rdata;
  logic             pos_we, pos_re, acc_we, acc_re;
  logic [AW-1:0]    pos_raddr, acc_waddr, acc_raddr;
  logic [AC_W-1:0]  acc_wdata;
  logic [AW-1:0]    clr_q;
  logic [1:0]       ksel;

  dp_op_e     op;
  logic [2:0] k;
  assign op = cmd_i.op;
  assign k  = cmd_i.k;
  assign ksel = (k < 3'd3) ? k[1:0] : 2'd0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ok[i] = IDX_EXT_W'(idx_q[i]) < IDX_EXT_W'(VERTEX_COUNT);
    end
  end

  // ---------------- memories ----------------
  assign pos_we    = (op == OP_WRITE) && ok[0];
  assign pos_re    = (op == OP_POS_RD) && (k < 3'd3);
  assign pos_raddr = to_addr(idx_q[ksel]);

  vna_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_COUNT), .AW(AW)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (to_addr(idx_q[0])),
    .wdata_i (posw_q),
    .re_i    (pos_re),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  logic signed [NRM_W-1:0] nrm_q [3];
  logic [AC_W-1:0]         sat_data;

  always_comb begin
    logic signed [ACC_WIDTH-1:0] cur;
    logic signed [ACC_WIDTH:0]   sum;
    sat_data = '0;
    for (int i = 0; i < 3; i++) begin
      cur = acc_rdata[i*ACC_WIDTH +: ACC_WIDTH];
      sum = $signed({cur[ACC_WIDTH-1], cur})
          + $signed({{(ACC_WIDTH-15){nrm_q[i][NRM_W-1]}}, nrm_q[i]});
      if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
        // clamp to the most negative or most positive code
        sat_data[i*ACC_WIDTH +: ACC_WIDTH] =
          {sum[ACC_WIDTH], {(ACC_WIDTH-1){~sum[ACC_WIDTH]}}};
      end else begin
        sat_data[i*ACC_WIDTH +: ACC_WIDTH] = sum[ACC_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = to_addr(idx_q[ksel]);
    acc_wdata = '0;
    case (op)
      OP_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_q;
      end
      OP_WRITE: begin
        acc_we    = ok[0];
        acc_waddr = to_addr(idx_q[0]);
      end
      OP_ACC_WR: begin
        acc_we    = 1'b1;
        acc_wdata = sat_data;
      end
      default: ;
    endcase
  end

  assign acc_re    = (op == OP_ACC_RD);
  assign acc_raddr = to_addr(idx_q[ksel]);

  vna_ram #(.WIDTH(AC_W), .DEPTH(VERTEX_COUNT), .AW(AW)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // ---------------- cross product ----------------
  logic signed [POS_W:0]   e1 [3];
  logic signed [POS_W:0]   e2 [3];
  logic signed [POS_W:0]   mul_a, mul_b;
  logic signed [2*POS_W+1:0] prod_q, first_q;
  logic [VEC_W-1:0]        vec_q [3];
  logic [1:0]              vidx;

  always_comb begin
    logic signed [POS_W-1:0] a0, b0, c0;
    for (int i = 0; i < 3; i++) begin
      a0 = p_q[0][i*POS_W +: POS_W];
      b0 = p_q[1][i*POS_W +: POS_W];
      c0 = p_q[2][i*POS_W +: POS_W];
      e1[i] = (POS_W+1)'(b0) - (POS_W+1)'(a0);
      e2[i] = (POS_W+1)'(c0) - (POS_W+1)'(a0);
    end
  end

  always_comb begin
    case (k)
      3'd0: begin mul_a = e1[1]; mul_b = e2[2]; end
      3'd1: begin mul_a = e1[2]; mul_b = e2[1]; end
      3'd2: begin mul_a = e1[2]; mul_b = e2[0]; end
      3'd3: begin mul_a = e1[0]; mul_b = e2[2]; end
      3'd4: begin mul_a = e1[0]; mul_b = e2[1]; end
      default: begin mul_a = e1[1]; mul_b = e2[0]; end
    endcase
  end

  assign vidx = 2'(k[2:1] - 2'd1);

  // ---------------- normaliser ----------------
  logic [VEC_W-1:0] mag_q [3];
  logic [2:0]       sgn_q;
  logic [VEC_W-1:0] m_max;
  logic [59:0]      prod2_q;
  logic [61:0]      s_q;
  logic [61:0]      rem_q;
  logic [62:0]      res_q;
  logic [62:0]      bit_q;
  logic [62:0]      trial;
  logic [47:0]      num_q, dsh_q;
  logic [15:0]      quo_q;
  logic [31:0]      root;
  logic             zero_q;
  logic             out_valid_q;
  logic             div_ge;

  always_comb begin
    m_max = mag_q[0];
    if (mag_q[1] > m_max) m_max = mag_q[1];
    if (mag_q[2] > m_max) m_max = mag_q[2];
  end

  assign trial  = res_q + bit_q;
  assign root   = res_q[31:0];
  assign div_ge = num_q >= dsh_q;

  always_ff @(posedge clk_i) begin
    case (op)
      OP_CAPTURE: begin
        func_q   <= func_e'(s_tuser_i);
        idx_q[0] <= s_tdata_i[9:0];
        idx_q[1] <= s_tdata_i[19:10];
        idx_q[2] <= s_tdata_i[29:20];
        posw_q   <= s_tdata_i[77:30];
      end
      OP_POS_RD: begin
        if (k != 3'd0) p_q[2'(k - 3'd1)] <= pos_rdata;
      end
      OP_CROSS: begin
        if (k < 3'd6) prod_q <= mul_a * mul_b;
        if (k[0]) begin
          first_q <= prod_q;
        end else if (k != 3'd0) begin
          vec_q[vidx] <= VEC_W'(first_q) - VEC_W'(prod_q);
        end
      end
      OP_LOAD_ACC: begin
        for (int i = 0; i < 3; i++) begin
          vec_q[i] <= VEC_W'($signed(acc_rdata[i*ACC_WIDTH +: ACC_WIDTH]));
        end
      end
      OP_NRM_LOAD: begin
        zero_q <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          sgn_q[i] <= vec_q[i][VEC_W-1];
          mag_q[i] <= vec_q[i][VEC_W-1] ? (~vec_q[i] + VEC_W'(1)) : vec_q[i];
        end
      end
      OP_NRM_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (|m_max[VEC_W-1:30]) mag_q[i] <= mag_q[i] >> 1;
          else                    mag_q[i] <= mag_q[i] << 1;
        end
      end
      OP_SQ: begin
        if (k == 3'd0) s_q <= '0;
        else           s_q <= s_q + 62'(prod2_q);
        if (k < 3'd3) prod2_q <= mag_q[ksel][29:0] * mag_q[ksel][29:0];
      end
      OP_SQRT_INIT: begin
        rem_q <= s_q;
        res_q <= '0;
        bit_q <= 63'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if ({1'b0, rem_q} >= trial) begin
          rem_q <= 62'({1'b0, rem_q} - trial);
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_DIV_INIT: begin
        num_q <= {3'd0, mag_q[ksel][29:0], 15'd0} + 48'(root);
        dsh_q <= {root, 16'd0};
        quo_q <= '0;
      end
      OP_DIV_STEP: begin
        if (div_ge) num_q <= num_q - dsh_q;
        dsh_q <= dsh_q >> 1;
        quo_q <= {quo_q[14:0], div_ge};
      end
      OP_DIV_STORE: begin
        nrm_q[ksel] <= sgn_q[ksel] ? -$signed(quo_q) : $signed(quo_q);
      end
      OP_ZERO: begin
        zero_q <= 1'b1;
        for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
      end
      OP_OUT: begin
        m_tdata_o <= {nrm_q[2], nrm_q[1], nrm_q[0]};
        m_tuser_o <= zero_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op == OP_CLEAR) clr_q <= clr_q + AW'(1);
      if (op == OP_OUT)       out_valid_q <= 1'b1;
      else if (m_tready_i)    out_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_valid_q;

  always_comb begin
    status_o.func     = func_q;
    status_o.a_ok     = ok[0];
    status_o.tri_ok   = &ok;
    status_o.m_zero   = (m_max == '0);
    status_o.m_big    = |m_max[VEC_W-1:30];
    status_o.m_small  = ~|m_max[VEC_W-1:29];
    status_o.out_full = out_valid_q;
    status_o.clr_last = (clr_q == AW'(VERTEX_COUNT - 1));
  end

endmodule

// ===== sv/vna_ctrl.sv =====
// Controller: sequences the datapath through each item.
// Depends on vna_pkg.
module vna_ctrl import vna_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [18:0] {
    ST_CLEAR   = 19'b1 << 0,
    ST_IDLE    = 19'b1 << 1,
    ST_DECODE  = 19'b1 << 2,
    ST_PRD     = 19'b1 << 3,
    ST_CROSS   = 19'b1 << 4,
    ST_ARDR    = 19'b1 << 5,
    ST_LOADACC = 19'b1 << 6,
    ST_NLOAD   = 19'b1 << 7,
    ST_NCHK    = 19'b1 << 8,
    ST_SQ      = 19'b1 << 9,
    ST_SQRTI   = 19'b1 << 10,
    ST_SQRT    = 19'b1 << 11,
    ST_DIVI    = 19'b1 << 12,
    ST_DIVS    = 19'b1 << 13,
    ST_DSTORE  = 19'b1 << 14,
    ST_ZERO    = 19'b1 << 15,
    ST_OUTW    = 19'b1 << 16,
    ST_ARD     = 19'b1 << 17,
    ST_AWR     = 19'b1 << 18
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] k_q, k_d;
  logic [4:0] cnt_q, cnt_d;
  logic       tri_q, tri_d;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    tri_d      = tri_q;
    cmd_o.op   = OP_NONE;
    cmd_o.k    = k_q;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        k_d = '0;
        unique case (status_i.func)
          FUNC_WRITE: begin
            cmd_o.op = OP_WRITE;
            state_d  = ST_IDLE;
          end
          FUNC_TRI: begin
            tri_d   = 1'b1;
            state_d = status_i.tri_ok ? ST_PRD : ST_IDLE;
          end
          FUNC_READ: begin
            tri_d   = 1'b0;
            state_d = status_i.a_ok ? ST_ARDR : ST_ZERO;
          end
          FUNC_NONE: state_d = ST_IDLE;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_PRD: begin
        cmd_o.op = OP_POS_RD;
        if (k_q == 3'd3) begin
          k_d     = '0;
          state_d = ST_CROSS;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      ST_CROSS: begin
        cmd_o.op = OP_CROSS;
        if (k_q == 3'd6) state_d = ST_NLOAD;
        else             k_d = k_q + 3'd1;
      end
      ST_ARDR: begin
        cmd_o.op = OP_ACC_RD;
        cmd_o.k  = '0;
        state_d  = ST_LOADACC;
      end
      ST_LOADACC: begin
        cmd_o.op = OP_LOAD_ACC;
        state_d  = ST_NLOAD;
      end
      ST_NLOAD: begin
        cmd_o.op = OP_NRM_LOAD;
        state_d  = ST_NCHK;
      end
      ST_NCHK: begin
        k_d = '0;
        if (status_i.m_zero) begin
          state_d = tri_q ? ST_IDLE : ST_ZERO;
        end else if (status_i.m_big || status_i.m_small) begin
          cmd_o.op = OP_NRM_SHIFT;
        end else begin
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.op = OP_SQ;
        if (k_q == 3'd3) state_d = ST_SQRTI;
        else             k_d = k_q + 3'd1;
      end
      ST_SQRTI: begin
        cmd_o.op = OP_SQRT_INIT;
        cnt_d    = '0;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          k_d     = '0;
          state_d = ST_DIVI;
        end
      end
      ST_DIVI: begin
        cmd_o.op = OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = ST_DIVS;
      end
      ST_DIVS: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'd15) state_d = ST_DSTORE;
      end
      ST_DSTORE: begin
        cmd_o.op = OP_DIV_STORE;
        if (k_q == 3'd2) begin
          k_d     = '0;
          state_d = tri_q ? ST_ARD : ST_OUTW;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = ST_DIVI;
        end
      end
      ST_ZERO: begin
        cmd_o.op = OP_ZERO;
        state_d  = ST_OUTW;
      end
      ST_OUTW: begin
        if (!status_i.out_full) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      ST_ARD: begin
        cmd_o.op = OP_ACC_RD;
        state_d  = ST_AWR;
      end
      ST_AWR: begin
        cmd_o.op = OP_ACC_WR;
        if (k_q == 3'd2) begin
          state_d = ST_IDLE;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = ST_ARD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      k_q     <= '0;
      cnt_q   <= '0;
      tri_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      tri_q   <= tri_d;
    end
  end

endmodule

// ===== sv/vertex_normal_accumulator.sv =====
// Vertex normal accumulator: one item at a time, sequenced by vna_ctrl.
// A write item passes a capture and a decode state. A triangle's run time
// is set by the bit-per-cycle normalising shift, 32-step square root and
// three 16-step divisions. A read runs the same normaliser plus handshake.
// Reset: asynchronous, active low; then a clearing pass steps through every
// accumulator RAM entry and zeroes it before the first item is taken.
module vertex_normal_accumulator import vna_pkg::*; #(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
  parameter int ACC_WIDTH    = ACC_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // index_a[9:0], index_b[19:10], index_c[29:20], pos_x[45:30],
  // pos_y[61:46], pos_z[77:62], zero padding [79:78]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // func[1:0]
  input  logic [1:0]            s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // normal_x[15:0], normal_y[31:16], normal_z[47:32]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // zero_length[0]
  output logic                  m_axis_tuser_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence every item; hold the input side while the datapath works.
  vna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Storage, arithmetic and the output register that parts the two sides.
  vna_datapath #(
    .VERTEX_COUNT (VERTEX_COUNT),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule
